>>> sv/gsct_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// Package for the game and shot clock timer: widths, reset values,
// register indexes, shared structs and the seven-segment helpers. No dependencies.
package gsct_pkg;

  localparam int GSCT_DEBOUNCE_SAMPLES = 8;
  localparam int GSCT_DIGITS           = 6;
  localparam int GSCT_NKEYS            = 3;

  localparam int CFG_DATA_W  = 16;
  localparam int CFG_INDEX_W = 2;
  localparam int TPS_W       = 16;
  localparam int MIN_W       = 7;
  localparam int SEC_W       = 6;
  localparam int SHOT_W      = 7;
  localparam int BUZZ_W      = 16;
  localparam int DIGIT_W     = 3;
  localparam int SEG_W       = 8;

  localparam logic [TPS_W-1:0]  TPS_RESET    = 16'd500;
  localparam logic [MIN_W-1:0]  GAME_RESET   = 7'd12;
  localparam logic [SHOT_W-1:0] RELOAD_RESET = 7'd24;
  localparam logic [BUZZ_W-1:0] BUZZ_RESET   = 16'd250;
  localparam logic [MIN_W-1:0]  CLOCK_MAX    = 7'd99;
  localparam logic [SEC_W-1:0]  SEC_MAX      = 6'd59;
  localparam logic [DIGIT_W-1:0] LAST_DIGIT  = DIGIT_W'(GSCT_DIGITS - 1);
  localparam logic [DIGIT_W-1:0] DP_DIGIT    = 3'd2;
  localparam logic [SEG_W-1:0]  DP_MASK      = 8'h7F;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_TICKS_PER_SECOND = 2'd0,
    REG_GAME_MINUTES     = 2'd1,
    REG_SHOT_RELOAD      = 2'd2,
    REG_BUZZ_TICKS       = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic run;
    logic shot;
    logic reset;
  } key_press_t;

  typedef struct packed {
    logic [TPS_W-1:0]  ticks_per_second;
    logic [MIN_W-1:0]  game_minutes;
    logic [SHOT_W-1:0] shot_reload;
    logic [BUZZ_W-1:0] buzz_ticks;
  } cfg_t;

  typedef struct packed {
    logic              buzzer_on;
    logic              running;
    logic              alarm;
    logic [MIN_W-1:0]  minutes;
    logic [SEC_W-1:0]  seconds;
    logic [SHOT_W-1:0] shot_left;
  } clock_view_t;

  // Active-low patterns, decimal point off.
  function automatic logic [SEG_W-1:0] seg_pattern(input logic [3:0] v);
    logic [SEG_W-1:0] p;
    unique case (v)
      4'd0:    p = 8'hC0;
      4'd1:    p = 8'hF9;
      4'd2:    p = 8'hA4;
      4'd3:    p = 8'hB0;
      4'd4:    p = 8'h99;
      4'd5:    p = 8'h92;
      4'd6:    p = 8'h82;
      4'd7:    p = 8'hF8;
      4'd8:    p = 8'h80;
      4'd9:    p = 8'h90;
      default: p = 8'hC0;
    endcase
    return p;
  endfunction

  // Tens digit of 0..127 by reciprocal multiply (x * 205) >> 11.
  function automatic logic [3:0] tens_of(input logic [6:0] v);
    logic [14:0] p;
    p = 15'(v) * 15'd205;
    return p[14:11];
  endfunction

  function automatic logic [3:0] ones_of(input logic [6:0] v);
    logic [6:0] t;
    t = 7'(tens_of(v)) * 7'd10;
    return 4'(v - t);
  endfunction

endpackage
`default_nettype wire

>>> sv/gsct_if.sv
`timescale 1ns / 1ps
`default_nettype none
// Valid/ready channels of the timer: key samples in, clock results out.
// Depends on gsct_pkg for field widths.
interface gsct_in_if;
  logic valid;
  logic ready;
  logic key_run;
  logic key_shot;
  logic key_reset;
  modport source (output valid, key_run, key_shot, key_reset, input ready);
  modport sink (input valid, key_run, key_shot, key_reset, output ready);
endinterface

interface gsct_out_if import gsct_pkg::*;;
  logic              valid;
  logic              ready;
  logic [DIGIT_W-1:0] scan_digit;
  logic [SEG_W-1:0]  segments;
  logic              buzzer_on;
  logic              running;
  logic              alarm;
  logic [MIN_W-1:0]  minutes;
  logic [SEC_W-1:0]  seconds;
  logic [SHOT_W-1:0] shot_left;
  modport source (output valid, scan_digit, segments, buzzer_on, running, alarm,
                  minutes, seconds, shot_left, input ready);
  modport sink (input valid, scan_digit, segments, buzzer_on, running, alarm,
                minutes, seconds, shot_left, output ready);
endinterface
`default_nettype wire

>>> sv/gsct_debounce.sv
`timescale 1ns / 1ps
`default_nettype none
// Shift-history debouncer for one active-low key; flags a press on the
// tick the stable level falls. Depends on gsct_pkg.
module gsct_debounce import gsct_pkg::*; #(
  parameter int SAMPLES = GSCT_DEBOUNCE_SAMPLES
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic en,
  input  wire logic key_raw,
  output logic      press
);

  logic [SAMPLES-1:0] history;
  logic [SAMPLES-1:0] history_next;
  logic               stable;
  logic               stable_next;

  always_comb begin
    history_next = {history[SAMPLES-2:0], key_raw};
    stable_next  = stable;
    if (history_next == '0) begin
      stable_next = 1'b0;
    end else if (history_next == '1) begin
      stable_next = 1'b1;
    end
  end

  assign press = en & stable & ~stable_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      history <= '1;
      stable  <= 1'b1;
    end else if (en) begin
      history <= history_next;
      stable  <= stable_next;
    end
  end

endmodule
`default_nettype wire

>>> sv/gsct_core.sv
`timescale 1ns / 1ps
`default_nettype none
// Clock state: key actions, prescaler, game and shot countdown, buzzer
// and scan index. Presents the state after the current tick. Depends on gsct_pkg.
module gsct_core import gsct_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        en,
  input  wire key_press_t  press,
  input  wire cfg_t        cfg,
  output clock_view_t      view,
  output logic [DIGIT_W-1:0] digit
);

  logic              running, running_next;
  logic              alarm, alarm_next;
  logic              phase, phase_next;
  logic [TPS_W-1:0]  prescale, prescale_next;
  logic [MIN_W-1:0]  minutes, minutes_next;
  logic [SEC_W-1:0]  seconds, seconds_next;
  logic [SHOT_W-1:0] shot, shot_next;
  logic [BUZZ_W-1:0] buzz, buzz_next;
  logic [DIGIT_W-1:0] scan_index, scan_index_next;

  logic [TPS_W-1:0]  pre_inc;
  logic              sec_step;
  logic [MIN_W-1:0]  min_dec;
  logic [SEC_W-1:0]  sec_dec;
  logic              zero_now;
  logic              zero_after;
  logic              buzz_out;

  always_comb begin
    // key actions
    running_next = running ^ (press.run & ~alarm);
    alarm_next   = alarm;
    phase_next   = phase;
    minutes_next = minutes;
    seconds_next = seconds;
    buzz_next    = buzz;
    shot_next    = shot;
    if (press.shot && !alarm &&
        (minutes != '0 || 7'(seconds) >= cfg.shot_reload)) begin
      shot_next = cfg.shot_reload;
    end
    if (press.reset) begin
      running_next = 1'b0;
      alarm_next   = 1'b0;
      phase_next   = 1'b0;
      minutes_next = cfg.game_minutes;
      seconds_next = '0;
      shot_next    = cfg.shot_reload;
      buzz_next    = '0;
    end

    // prescaler and countdown second
    pre_inc       = prescale + 1'b1;
    sec_step      = pre_inc >= cfg.ticks_per_second;
    prescale_next = sec_step ? '0 : pre_inc;

    zero_now = (minutes_next == '0) && (seconds_next == '0);
    if (seconds_next == '0) begin
      sec_dec = SEC_MAX;
      min_dec = minutes_next - 1'b1;
    end else begin
      sec_dec = seconds_next - 1'b1;
      min_dec = minutes_next;
    end
    zero_after = (min_dec == '0) && (sec_dec == '0);

    if (sec_step && running_next) begin
      if (zero_now) begin
        running_next = 1'b0;
        alarm_next   = 1'b1;
        buzz_next    = '0;
      end else begin
        minutes_next = min_dec;
        seconds_next = sec_dec;
        if (zero_after) begin
          running_next = 1'b0;
          alarm_next   = 1'b1;
          buzz_next    = '0;
        end else if (shot_next != '0) begin
          shot_next = shot_next - 1'b1;
        end else if (!(min_dec == '0 && 7'(sec_dec) < cfg.shot_reload)) begin
          shot_next = cfg.shot_reload;
          buzz_next = cfg.buzz_ticks;
        end
      end
    end

    // buzzer: toggle during alarm, else count the remaining ticks down
    if (alarm_next) begin
      phase_next = ~phase_next;
      buzz_out   = phase_next;
    end else begin
      buzz_out = buzz_next != '0;
      if (buzz_out) begin
        buzz_next = buzz_next - 1'b1;
      end
    end

    digit           = (scan_index > LAST_DIGIT) ? '0 : scan_index;
    scan_index_next = (digit == LAST_DIGIT) ? '0 : digit + 1'b1;
  end

  assign view = '{buzzer_on: buzz_out, running: running_next, alarm: alarm_next,
                  minutes: minutes_next, seconds: seconds_next, shot_left: shot_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      running    <= 1'b0;
      alarm      <= 1'b0;
      phase      <= 1'b0;
      prescale   <= '0;
      minutes    <= GAME_RESET;
      seconds    <= '0;
      shot       <= RELOAD_RESET;
      buzz       <= '0;
      scan_index <= '0;
    end else if (en) begin
      running    <= running_next;
      alarm      <= alarm_next;
      phase      <= phase_next;
      prescale   <= prescale_next;
      minutes    <= minutes_next;
      seconds    <= seconds_next;
      shot       <= shot_next;
      buzz       <= buzz_next;
      scan_index <= scan_index_next;
    end
  end

endmodule
`default_nettype wire

>>> sv/gsct_seg.sv
`timescale 1ns / 1ps
`default_nettype none
// Seven-segment decode of the scanned digit: picks the clock value,
// splits it into tens and ones and maps to an active-low pattern. Depends on gsct_pkg.
module gsct_seg import gsct_pkg::*; (
  input  wire logic [DIGIT_W-1:0] digit,
  input  wire clock_view_t        view,
  output logic [SEG_W-1:0]        segments
);

  logic [6:0] value;
  logic [3:0] num;
  logic       use_tens;

  always_comb begin
    unique case (digit)
      3'd0, 3'd1: value = view.shot_left;
      3'd2, 3'd3: value = 7'(view.seconds);
      default:    value = view.minutes;
    endcase
    use_tens = digit[0];
    num      = use_tens ? tens_of(value) : ones_of(value);
    if (view.alarm) begin
      num = '0;
    end
    segments = seg_pattern(num);
    if (digit == DP_DIGIT) begin
      segments = segments & DP_MASK;
    end
  end

endmodule
`default_nettype wire

>>> sv/game_and_shot_clock_timer_top.sv
`timescale 1ns / 1ps
`default_nettype none
// Basketball game clock and shot clock, one scan tick per transaction.
//
// key_in carries one scan tick with the three raw key levels (low means
// pressed). result_out carries one result per tick: the scanned digit and
// its active-low segments, the buzzer drive, run and alarm flags, and the
// game and shot clock values after the tick. Registers are written through
// cfg_we / cfg_index / cfg_wdata; the user must do so only while no tick is in
// flight (not enforced). game_minutes/shot_reload: cfg_wdata[6:0], capped at 99.
//
// An accepted tick sits in the input register while the state update and
// display decode work, and the result register loads when the tick advances
// into a free result register. Throughput is one tick per cycle while the
// receiver keeps taking results; the input register and the result register
// let a new tick enter while a result waits to be taken.
// When the receiver stalls, the result holds and the input register fills,
// after which key_in.ready drops until the result is taken.
// Reset (rst, synchronous) loads register defaults, releases all keys,
// stops the clocks at game_minutes:00 with the shot clock at shot_reload.
module game_and_shot_clock_timer_top import gsct_pkg::*; #(
  parameter int DEBOUNCE_SAMPLES = GSCT_DEBOUNCE_SAMPLES
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_wdata,
  gsct_in_if.sink                     key_in,
  gsct_out_if.source                  result_out
);

  cfg_t        cfg;
  logic [6:0]  cfg_small;
  logic [6:0]  cfg_sat;

  logic        in_valid;
  logic [2:0]  keys;
  logic        advance;
  key_press_t  press;
  clock_view_t view;
  logic [DIGIT_W-1:0] digit;
  logic [SEG_W-1:0]   segments;

  assign cfg_small = cfg_wdata[6:0];
  assign cfg_sat   = (cfg_small > CLOCK_MAX) ? CLOCK_MAX : cfg_small;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.ticks_per_second <= TPS_RESET;
      cfg.game_minutes     <= GAME_RESET;
      cfg.shot_reload      <= RELOAD_RESET;
      cfg.buzz_ticks       <= BUZZ_RESET;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_TICKS_PER_SECOND: cfg.ticks_per_second <= cfg_wdata;
        REG_GAME_MINUTES:     cfg.game_minutes     <= cfg_sat;
        REG_SHOT_RELOAD:      cfg.shot_reload      <= cfg_sat;
        REG_BUZZ_TICKS:       cfg.buzz_ticks       <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // move a tick into the core when the result register is free
  assign advance      = in_valid & (~result_out.valid | result_out.ready);
  assign key_in.ready = ~in_valid | advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (key_in.valid && key_in.ready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (key_in.valid && key_in.ready) begin
      keys <= {key_in.key_run, key_in.key_shot, key_in.key_reset};
    end
  end

  gsct_debounce #(.SAMPLES(DEBOUNCE_SAMPLES)) u_deb_run (
    .clk(clk), .rst(rst), .en(advance), .key_raw(keys[2]), .press(press.run)
  );
  gsct_debounce #(.SAMPLES(DEBOUNCE_SAMPLES)) u_deb_shot (
    .clk(clk), .rst(rst), .en(advance), .key_raw(keys[1]), .press(press.shot)
  );
  gsct_debounce #(.SAMPLES(DEBOUNCE_SAMPLES)) u_deb_reset (
    .clk(clk), .rst(rst), .en(advance), .key_raw(keys[0]), .press(press.reset)
  );

  gsct_core u_core (
    .clk(clk), .rst(rst), .en(advance), .press(press), .cfg(cfg),
    .view(view), .digit(digit)
  );

  gsct_seg u_seg (
    .digit(digit), .view(view), .segments(segments)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_out.valid <= 1'b0;
    end else if (advance) begin
      result_out.valid <= 1'b1;
    end else if (result_out.ready) begin
      result_out.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result_out.scan_digit <= digit;
      result_out.segments   <= segments;
      result_out.buzzer_on  <= view.buzzer_on;
      result_out.running    <= view.running;
      result_out.alarm      <= view.alarm;
      result_out.minutes    <= view.minutes;
      result_out.seconds    <= view.seconds;
      result_out.shot_left  <= view.shot_left;
    end
  end

  a_alarm_stops: assert property (@(posedge clk) disable iff (rst)
    result_out.valid && result_out.alarm |-> !result_out.running)
    else $error("clock running while alarm latched");

  a_seconds_range: assert property (@(posedge clk) disable iff (rst)
    result_out.valid |-> result_out.seconds <= SEC_MAX)
    else $error("game seconds out of range");

  a_clock_range: assert property (@(posedge clk) disable iff (rst)
    result_out.valid |-> result_out.minutes <= CLOCK_MAX && result_out.shot_left <= CLOCK_MAX)
    else $error("minutes or shot clock above 99");

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    result_out.valid && !result_out.ready |=> result_out.valid)
    else $error("result dropped while stalled");

endmodule
`default_nettype wire

>>> tb/game_and_shot_clock_timer_top_test.sv
`timescale 1ns / 1ps
// Testbench for the game and shot clock timer: drives raw, bouncing key sequences
// tick by tick and checks every result against a cycle-free predictor.
// Depends on gsct_pkg, gsct_in_if / gsct_out_if and game_and_shot_clock_timer_top.
module game_and_shot_clock_timer_top_test;
  import gsct_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 4;
  localparam int MAX_PRINTED    = 40;
  // Active-low digit patterns 0..9, digit 0 in the low byte.
  localparam logic [79:0] GLYPHS = {8'h90, 8'h80, 8'hF8, 8'h82, 8'h92,
                                    8'h99, 8'hB0, 8'hA4, 8'hF9, 8'hC0};

  typedef enum logic [1:0] {KEY_RUN = 2'd0, KEY_SHOT = 2'd1, KEY_RESET = 2'd2} key_id_t;

  typedef struct packed {
    logic [DIGIT_W-1:0] scan_digit;
    logic [SEG_W-1:0]   segments;
    logic               buzzer_on;
    logic               running;
    logic               alarm;
    logic [MIN_W-1:0]   minutes;
    logic [SEC_W-1:0]   seconds;
    logic [SHOT_W-1:0]  shot_left;
  } tick_result_t;

  logic                   clk;
  logic                   rst;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_wdata;

  gsct_in_if  key_ch ();
  gsct_out_if res_ch ();

  game_and_shot_clock_timer_top i_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .key_in     (key_ch),
    .result_out (res_ch)
  );

  // Predicted timer state and register copies
  logic [TPS_W-1:0]  cfg_tps;
  logic [MIN_W-1:0]  cfg_game;
  logic [SHOT_W-1:0] cfg_reload;
  logic [BUZZ_W-1:0] cfg_buzz;

  logic [GSCT_DEBOUNCE_SAMPLES-1:0] key_hist [GSCT_NKEYS];
  logic              key_level [GSCT_NKEYS];
  logic              key_seen [GSCT_NKEYS];
  logic              clock_running;
  logic              game_over;
  logic              buzz_phase;
  logic [TPS_W-1:0]  prescale_cnt;
  logic [MIN_W-1:0]  mins_left;
  logic [SEC_W-1:0]  secs_left;
  logic [SHOT_W-1:0] shot_count;
  logic [BUZZ_W-1:0] buzz_left;
  logic [DIGIT_W-1:0] digit_sel;

  tick_result_t expected_ticks [$];

  bit          idle_allowed;
  bit          gaps_on;
  bit          stalls_on;
  int unsigned ticks_sent;
  int unsigned results_checked;
  int unsigned mismatches;
  int unsigned settings_used;
  int unsigned shot_expiries;
  int unsigned games_ended;
  int unsigned quiet_cycles;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  task automatic load_game();
    clock_running = 1'b0;
    game_over     = 1'b0;
    buzz_phase    = 1'b0;
    mins_left     = cfg_game;
    secs_left     = '0;
    shot_count    = cfg_reload;
    buzz_left     = '0;
  endtask

  task automatic end_game();
    clock_running = 1'b0;
    game_over     = 1'b1;
    buzz_left     = '0;
    games_ended++;
  endtask

  // Advance the timer by one scan tick and produce the displayed result.
  task automatic predict_tick(input logic [2:0] levels, output tick_result_t r);
    logic [DIGIT_W-1:0] d;
    int unsigned        v;
    logic [SEG_W-1:0]   pat;
    for (int k = 0; k < GSCT_NKEYS; k++) begin
      key_hist[k] = {key_hist[k][GSCT_DEBOUNCE_SAMPLES-2:0], levels[k]};
      if (key_hist[k] == '0) key_level[k] = 1'b0;
      else if (key_hist[k] == '1) key_level[k] = 1'b1;
    end
    for (int k = 0; k < GSCT_NKEYS; k++) begin
      if (key_seen[k] != key_level[k]) begin
        // stable level went from released to pressed
        if (key_seen[k]) begin
          if (k == KEY_RESET) begin
            load_game();
          end else if (!game_over) begin
            if (k == KEY_RUN) clock_running = !clock_running;
            else if (mins_left != 0 || secs_left >= cfg_reload) shot_count = cfg_reload;
          end
        end
        key_seen[k] = key_level[k];
      end
    end

    prescale_cnt = prescale_cnt + 16'd1;
    if (prescale_cnt >= cfg_tps) begin
      prescale_cnt = '0;
      if (clock_running) begin
        if (mins_left == 0 && secs_left == 0) begin
          end_game();
        end else begin
          if (secs_left == 0) begin
            secs_left = SEC_MAX;
            mins_left = mins_left - 7'd1;
          end else begin
            secs_left = secs_left - 6'd1;
          end
          if (mins_left == 0 && secs_left == 0) begin
            end_game();
          end else if (shot_count != 0) begin
            shot_count = shot_count - 7'd1;
          end else if (!(mins_left == 0 && secs_left < cfg_reload)) begin
            shot_count = cfg_reload;
            buzz_left  = cfg_buzz;
            shot_expiries++;
          end
        end
      end
    end

    if (game_over) begin
      buzz_phase  = !buzz_phase;
      r.buzzer_on = buzz_phase;
    end else begin
      r.buzzer_on = (buzz_left != 0);
      if (r.buzzer_on) buzz_left = buzz_left - 16'd1;
    end

    d = (digit_sel > LAST_DIGIT) ? '0 : digit_sel;
    digit_sel = (d < LAST_DIGIT) ? d + 3'd1 : '0;
    case (d)
      3'd0:    v = shot_count % 10;
      3'd1:    v = (shot_count / 10) % 10;
      3'd2:    v = secs_left % 10;
      3'd3:    v = (secs_left / 10) % 10;
      3'd4:    v = mins_left % 10;
      default: v = (mins_left / 10) % 10;
    endcase
    if (game_over) v = 0;
    pat = GLYPHS[v*8 +: 8];
    if (d == DP_DIGIT) pat = pat & DP_MASK;

    r.scan_digit = d;
    r.segments   = pat;
    r.running    = clock_running;
    r.alarm      = game_over;
    r.minutes    = mins_left;
    r.seconds    = secs_left;
    r.shot_left  = shot_count;
  endtask

  task automatic report_mismatch(input string field, input int unsigned want,
                                 input int unsigned got);
    if (mismatches < MAX_PRINTED)
      $display("%0t: result %0d %s: expected %0d, got %0d",
               $realtime, results_checked, field, want, got);
    mismatches++;
  endtask

  // Bit 0 run, bit 1 shot, bit 2 reset; 0 means pressed.
  task automatic send_tick(input logic [2:0] levels);
    tick_result_t want;
    if (gaps_on && $urandom_range(3) == 0) begin
      key_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    key_ch.valid     <= 1'b1;
    key_ch.key_run   <= levels[KEY_RUN];
    key_ch.key_shot  <= levels[KEY_SHOT];
    key_ch.key_reset <= levels[KEY_RESET];
    do @(posedge clk); while (!key_ch.ready);
    predict_tick(levels, want);
    expected_ticks.push_back(want);
    ticks_sent++;
  endtask

  // Drain all results, let the pipeline settle, then write every register.
  task automatic write_registers(input logic [15:0] tps, input logic [15:0] gm,
                                 input logic [15:0] sr, input logic [15:0] bz);
    key_ch.valid <= 1'b0;
    while (expected_ticks.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= REG_TICKS_PER_SECOND;
    cfg_wdata <= tps;
    @(posedge clk);
    cfg_index <= REG_GAME_MINUTES;
    cfg_wdata <= gm;
    @(posedge clk);
    cfg_index <= REG_SHOT_RELOAD;
    cfg_wdata <= sr;
    @(posedge clk);
    cfg_index <= REG_BUZZ_TICKS;
    cfg_wdata <= bz;
    @(posedge clk);
    cfg_we <= 1'b0;
    cfg_tps    = tps;
    cfg_game   = (gm[6:0] > CLOCK_MAX) ? CLOCK_MAX : gm[6:0];
    cfg_reload = (sr[6:0] > CLOCK_MAX) ? CLOCK_MAX : sr[6:0];
    cfg_buzz   = bz;
    settings_used++;
  endtask

  // Clean press and release, sometimes with contact bounce up front.
  task automatic press_key(input key_id_t which);
    logic [2:0] lv;
    lv = 3'b111;
    if ($urandom_range(3) == 0) begin
      repeat ($urandom_range(1, 4)) begin
        lv[which] = 1'($urandom_range(1));
        send_tick(lv);
      end
    end
    lv[which] = 1'b0;
    repeat ($urandom_range(8, 12)) send_tick(lv);
    lv[which] = 1'b1;
    repeat ($urandom_range(8, 12)) send_tick(lv);
  endtask

  task automatic new_game(input logic [15:0] tps, input logic [15:0] gm,
                          input logic [15:0] sr, input logic [15:0] bz);
    write_registers(tps, gm, sr, bz);
    press_key(KEY_RESET);
  endtask

  // Mostly well-formed key presses and idle stretches, some raw noise.
  task automatic play_episodes(input int unsigned count);
    int unsigned stop_at;
    int unsigned pick;
    stop_at = ticks_sent + count;
    while (ticks_sent < stop_at) begin
      gaps_on   = idle_allowed && $urandom_range(2) != 0;
      stalls_on = idle_allowed && $urandom_range(2) != 0;
      pick = $urandom_range(99);
      if (pick < 30) press_key(KEY_RUN);
      else if (pick < 50) press_key(KEY_SHOT);
      else if (pick < 58) press_key(KEY_RESET);
      else if (pick < 85) repeat ($urandom_range(1, 40)) send_tick(3'b111);
      else repeat ($urandom_range(1, 10)) send_tick(3'($urandom_range(7)));
    end
  endtask

  task automatic test_directed_keys();
    write_registers(16'd0, 16'd1, 16'd3, 16'd2);
    // all keys at once: run, shot reload, then full reset wins
    repeat (GSCT_DEBOUNCE_SAMPLES) send_tick(3'b000);
    repeat (GSCT_DEBOUNCE_SAMPLES) send_tick(3'b111);
    // start the clocks; every tick is a second
    repeat (GSCT_DEBOUNCE_SAMPLES) send_tick(3'b110);
  endtask

  task automatic test_shot_clock();
    new_game(16'd0, 16'd2, 16'd2, 16'd3);
    press_key(KEY_RUN);
    play_episodes(100);
    new_game(16'd1, 16'd3, 16'd0, 16'd0);
    press_key(KEY_RUN);
    play_episodes(50);
  endtask

  task automatic test_game_over();
    // zero game time: the first running second latches the alarm
    new_game(16'd0, 16'd0, 16'd5, 16'd4);
    press_key(KEY_RUN);
    press_key(KEY_RUN);
    press_key(KEY_SHOT);
    press_key(KEY_RESET);
    // count down a full minute; shot reload is refused near the end
    new_game(16'd0, 16'd1, 16'd20, 16'd6);
    press_key(KEY_RUN);
    repeat (30) send_tick(3'b111);
    press_key(KEY_SHOT);
    repeat (30) send_tick(3'b111);
    play_episodes(100);
  endtask

  task automatic test_register_extremes();
    new_game(16'hFFFF, 16'hFFFF, 16'h007F, 16'hFFFF);
    press_key(KEY_RUN);
    play_episodes(60);
    // prescaler carries over from the slow setting
    new_game(16'd0, 16'hFF80, 16'd0, 16'd0);
    press_key(KEY_RUN);
    play_episodes(70);
    new_game(16'd1, 16'd99, 16'd99, 16'd1);
    press_key(KEY_RUN);
    play_episodes(70);
  endtask

  task automatic test_random_settings();
    repeat (4) begin
      new_game(16'($urandom_range(0, 4)), 16'($urandom_range(0, 3)),
               16'($urandom_range(0, 12)), 16'($urandom_range(0, 20)));
      play_episodes(50);
    end
  endtask

  task automatic test_back_to_back();
    idle_allowed = 1'b0;
    gaps_on      = 1'b0;
    stalls_on    = 1'b0;
    new_game(16'd1, 16'd1, 16'd6, 16'd3);
    press_key(KEY_RUN);
    play_episodes(130);
  endtask

  // Receiver side: random stall bursts while allowed.
  initial begin
    res_ch.ready = 1'b0;
    @(posedge clk);
    forever begin
      if (stalls_on && $urandom_range(2) == 0) begin
        res_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
      res_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  end

  always @(posedge clk) begin : check_results
    tick_result_t want;
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (expected_ticks.size() == 0) begin
        report_mismatch("result with no tick pending", 0, 1);
      end else begin
        want = expected_ticks.pop_front();
        if (res_ch.scan_digit !== want.scan_digit)
          report_mismatch("scan_digit", want.scan_digit, res_ch.scan_digit);
        if (res_ch.segments !== want.segments)
          report_mismatch("segments", want.segments, res_ch.segments);
        if (res_ch.buzzer_on !== want.buzzer_on)
          report_mismatch("buzzer_on", want.buzzer_on, res_ch.buzzer_on);
        if (res_ch.running !== want.running)
          report_mismatch("running", want.running, res_ch.running);
        if (res_ch.alarm !== want.alarm)
          report_mismatch("alarm", want.alarm, res_ch.alarm);
        if (res_ch.minutes !== want.minutes)
          report_mismatch("minutes", want.minutes, res_ch.minutes);
        if (res_ch.seconds !== want.seconds)
          report_mismatch("seconds", want.seconds, res_ch.seconds);
        if (res_ch.shot_left !== want.shot_left)
          report_mismatch("shot_left", want.shot_left, res_ch.shot_left);
        results_checked++;
      end
    end
  end

  // End the run when nothing moves for too long.
  always @(posedge clk) begin
    if (rst || cfg_we || (key_ch.valid && key_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout: no transaction for %0d cycles, %0d results pending",
               quiet_cycles, expected_ticks.size());
      $display("FAIL game_and_shot_clock_timer_top");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst              = 1'b1;
    cfg_we           = 1'b0;
    cfg_index        = REG_TICKS_PER_SECOND;
    cfg_wdata        = '0;
    key_ch.valid     = 1'b0;
    key_ch.key_run   = 1'b1;
    key_ch.key_shot  = 1'b1;
    key_ch.key_reset = 1'b1;
    idle_allowed     = 1'b0;
    gaps_on          = 1'b0;
    stalls_on        = 1'b0;
    ticks_sent       = 0;
    results_checked  = 0;
    mismatches       = 0;
    settings_used    = 0;
    shot_expiries    = 0;
    games_ended      = 0;
    quiet_cycles     = 0;

    cfg_tps    = TPS_RESET;
    cfg_game   = GAME_RESET;
    cfg_reload = RELOAD_RESET;
    cfg_buzz   = BUZZ_RESET;
    for (int k = 0; k < GSCT_NKEYS; k++) begin
      key_hist[k]  = '1;
      key_level[k] = 1'b1;
      key_seen[k]  = 1'b1;
    end
    prescale_cnt = '0;
    digit_sel    = '0;
    load_game();

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed_keys();
    idle_allowed = 1'b1;
    test_shot_clock();
    test_game_over();
    test_register_extremes();
    test_random_settings();
    test_back_to_back();

    key_ch.valid <= 1'b0;
    while (expected_ticks.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Checked %0d results from %0d scan ticks under %0d register settings;",
             results_checked, ticks_sent, settings_used);
    $display("the run saw %0d shot clock expiries and %0d games run out.",
             shot_expiries, games_ended);
    if (mismatches == 0) begin
      $display("PASS game_and_shot_clock_timer_top");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("FAIL game_and_shot_clock_timer_top");
    end
    $finish;
  end

endmodule
